FILE: sv/ips_pkg.sv
package ips_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = DATA_W / 2;
    localparam int EXP_W  = 32;
    localparam int PC_W   = 3;

    // what a step waits for before it completes
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_IN   = 2'd1;
    localparam logic [1:0] W_MUL  = 2'd2;
    localparam logic [1:0] W_OUT  = 2'd3;

    // where the step counter goes once the step completes
    localparam logic [1:0] B_SEQ   = 2'd0;
    localparam logic [1:0] B_JMP   = 2'd1;
    localparam logic [1:0] B_EZERO = 2'd2;
    localparam logic [1:0] B_EBIT0 = 2'd3;

    // program steps
    localparam logic [PC_W-1:0] S_IDLE = 3'd0;
    localparam logic [PC_W-1:0] S_TEST = 3'd1;
    localparam logic [PC_W-1:0] S_TBIT = 3'd2;
    localparam logic [PC_W-1:0] S_MACC = 3'd3;
    localparam logic [PC_W-1:0] S_MSQ  = 3'd4;
    localparam logic [PC_W-1:0] S_EMIT = 3'd5;

    typedef struct packed {
        logic [1:0]      wait_on;
        logic [1:0]      branch;
        logic [PC_W-1:0] target;
        logic            load;
        logic            go;
        logic            sel_sq;
        logic            wr_acc;
        logic            wr_sq;
        logic            shift_e;
        logic            emit;
    } t_uop;

    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '0;
        case (pc)
            S_IDLE: begin
                u.wait_on = W_IN;
                u.load    = 1'b1;
            end
            S_TEST: begin
                u.branch = B_EZERO;
                u.target = S_EMIT;
            end
            S_TBIT: begin
                u.branch = B_EBIT0;
                u.target = S_MSQ;
            end
            S_MACC: begin
                u.wait_on = W_MUL;
                u.go      = 1'b1;
                u.wr_acc  = 1'b1;
            end
            S_MSQ: begin
                u.wait_on = W_MUL;
                u.branch  = B_JMP;
                u.target  = S_TEST;
                u.go      = 1'b1;
                u.sel_sq  = 1'b1;
                u.wr_sq   = 1'b1;
                u.shift_e = 1'b1;
            end
            S_EMIT: begin
                u.wait_on = W_OUT;
                u.branch  = B_JMP;
                u.target  = S_IDLE;
                u.emit    = 1'b1;
            end
            default: begin
                u.branch = B_JMP;
                u.target = S_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

FILE: sv/integer_power_by_squaring.sv
// channel  direction  handshake          payload
// input    in         i_valid / o_stall  i_base (s64), i_exponent (u32)
// output   out        o_valid / i_stall  o_power (s64)
//
// one item at a time; microcode scans the exponent lsb first, testing each bit in S_TEST and S_TBIT
// a squaring and a set bit each run on the shared 32x32 multiplier
// i_rst_n is synchronous; o_stall is high whenever the sequencer is not idle
// a finished result waits in the output register while i_stall is high
module integer_power_by_squaring
    import ips_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_base,
    input  logic        [EXP_W-1:0]  i_exponent,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_power
);

    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_sq;
    logic [EXP_W-1:0]  r_e;
    logic [DATA_W-1:0] r_power;
    logic              r_out_valid;
    logic              n_out_valid;
    t_uop              uop;
    logic              step_done;
    logic              taken;
    logic              mul_done;
    logic [DATA_W-1:0] mul_p;

    assign uop = ucode(r_pc);

    ips_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (uop.go),
        .i_a     (uop.sel_sq ? r_sq : r_acc),
        .i_b     (r_sq),
        .o_p     (mul_p),
        .o_done  (mul_done)
    );

    always_comb begin
        case (uop.wait_on)
            W_NONE:  step_done = 1'b1;
            W_IN:    step_done = i_valid;
            W_MUL:   step_done = mul_done;
            W_OUT:   step_done = !r_out_valid || !i_stall;
            default: step_done = 1'b1;
        endcase
    end

    always_comb begin
        case (uop.branch)
            B_SEQ:   taken = 1'b0;
            B_JMP:   taken = 1'b1;
            B_EZERO: taken = (r_e == '0);
            B_EBIT0: taken = !r_e[0];
            default: taken = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (step_done) begin
            n_pc = taken ? uop.target : r_pc + PC_W'(1);
        end
    end

    assign n_out_valid = (r_out_valid && i_stall) || (uop.emit && step_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_done) begin
            if (uop.load) begin
                r_acc <= DATA_W'(1);
                r_sq  <= i_base;
                r_e   <= i_exponent;
            end
            if (uop.wr_acc) begin
                r_acc <= mul_p;
            end
            if (uop.wr_sq) begin
                r_sq <= mul_p;
            end
            if (uop.shift_e) begin
                r_e <= r_e >> 1;
            end
            if (uop.emit) begin
                r_power <= r_acc;
            end
        end
    end

    assign o_stall = (r_pc != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_power = r_power;

endmodule

FILE: sv/ips_mul.sv
module ips_mul
    import ips_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic [DATA_W-1:0] o_p,
    output logic              o_done
);

    // low half of a full-width product from three half-width products,
    // one 32x32 multiplier shared by the three products in turn
    logic [1:0]          r_ph;
    logic [1:0]          n_ph;
    logic [DATA_W-1:0]   r_prod;
    logic [DATA_W-1:0]   r_sum;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [DATA_W-1:0]   mul_p;
    logic [HALF_W-1:0]   hi_sum;

    always_comb begin
        case (r_ph)
            2'd0: begin
                mul_a = i_a[HALF_W-1:0];
                mul_b = i_b[HALF_W-1:0];
            end
            2'd1: begin
                mul_a = i_a[HALF_W-1:0];
                mul_b = i_b[DATA_W-1:HALF_W];
            end
            default: begin
                mul_a = i_a[DATA_W-1:HALF_W];
                mul_b = i_b[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p  = DATA_W'(mul_a) * DATA_W'(mul_b);
    assign hi_sum = r_sum[DATA_W-1:HALF_W] + r_prod[HALF_W-1:0];
    assign o_done = i_go && (r_ph == 2'd3);
    assign o_p    = {hi_sum, r_sum[HALF_W-1:0]};
    assign n_ph   = i_go ? r_ph + 2'd1 : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 2'd0;
        end else begin
            r_ph <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= mul_p;
            if (r_ph == 2'd1) begin
                r_sum <= r_prod;
            end else if (r_ph == 2'd2) begin
                r_sum <= o_p;
            end
        end
    end

endmodule

FILE: verif/testbench.sv
module testbench
    import ips_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 400;
    localparam int RAND_ITEMS  = 1930;

    typedef struct {
        logic signed [DATA_W-1:0] base;
        logic        [EXP_W-1:0]  exponent;
        logic signed [DATA_W-1:0] power;
    } t_power_expect;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_base;
    logic        [EXP_W-1:0]  i_exponent;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DATA_W-1:0] o_power;

    t_power_expect pending_powers[$];
    int            error_count    = 0;
    int            items_sent     = 0;
    int            powers_checked = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles   = 0;

    integer_power_by_squaring dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_power    (o_power)
    );

    always #6 i_clk = ~i_clk;

    // square-and-multiply, lsb first, every product keeps its low 64 bits
    function automatic logic [DATA_W-1:0] wrapped_power(input logic [DATA_W-1:0] base,
                                                        input logic [EXP_W-1:0]  exponent);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] square;
        acc    = 64'd1;
        square = base;
        for (int b = 0; b < EXP_W; b++) begin
            if (exponent[b]) begin
                acc = acc * square;
            end
            square = square * square;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // one transaction on the input channel; valid stays high on return
    task automatic send_power(input logic signed [DATA_W-1:0] base,
                              input logic        [EXP_W-1:0]  exponent);
        t_power_expect item;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        item.base     = base;
        item.exponent = exponent;
        item.power    = wrapped_power(base, exponent);
        pending_powers.push_back(item);
        items_sent++;
    endtask

    // result checker, receiver stall and watchdog
    initial begin
        t_power_expect want;
        logic          moved;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            moved = 1'b0;
            if (i_rst_n && i_valid && !o_stall) begin
                moved = 1'b1;
            end
            if (i_rst_n && o_valid && !i_stall) begin
                moved = 1'b1;
                if (pending_powers.size() == 0) begin
                    report_mismatch($sformatf("unexpected power %0d", o_power));
                end else begin
                    want = pending_powers.pop_front();
                    powers_checked++;
                    if (o_power !== want.power) begin
                        report_mismatch($sformatf("%0d ** %0d gave %0d, want %0d",
                            want.base, want.exponent, o_power, want.power));
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= HOLD_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d powers pending",
                         HOLD_LIMIT, pending_powers.size());
                $display("DONE: errors detected");
                $finish;
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic test_exponent_zero();
        send_power(64'sd0, 32'd0);
        send_power(64'sd5, 32'd0);
        send_power(64'h8000_0000_0000_0000, 32'd0);
        send_power(64'h7fff_ffff_ffff_ffff, 32'd0);
    endtask

    task automatic test_extreme_operands();
        send_power(64'sd0, 32'd1);
        send_power(64'sd0, 32'hffff_ffff);
        send_power(64'sd1, 32'hffff_ffff);
        send_power(-64'sd1, 32'hffff_ffff);
        send_power(-64'sd1, 32'hffff_fffe);
        send_power(64'h7fff_ffff_ffff_ffff, 32'd1);
        send_power(64'h8000_0000_0000_0000, 32'd1);
        send_power(64'h8000_0000_0000_0000, 32'd2);
        send_power(64'h7fff_ffff_ffff_ffff, 32'd2);
    endtask

    // products at and past the edge of the 64-bit range
    task automatic test_wraparound();
        send_power(64'sd2, 32'd62);
        send_power(64'sd2, 32'd63);
        send_power(64'sd2, 32'd64);
        send_power(-64'sd2, 32'd63);
        send_power(64'sd3, 32'hffff_ffff);
        send_power({$urandom, $urandom}, 32'hffff_ffff);
    endtask

    task automatic test_exponent_patterns();
        send_power(64'sd7, 32'h8000_0000);
        send_power(-64'sd7, 32'h5555_5555);
        send_power({$urandom, $urandom}, 32'haaaa_aaaa);
        send_power({$urandom, $urandom}, 32'h0001_0000);
    endtask

    task automatic test_random_traffic(input int count);
        logic signed [DATA_W-1:0] base;
        logic        [EXP_W-1:0]  exponent;
        int                       width;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 4))
                0, 1: base = {$urandom, $urandom};
                2: base = $signed(64'($urandom_range(0, 8))) - 64'sd4;
                3: begin
                    base = 64'sd1 <<< $urandom_range(0, 63);
                    if ($urandom_range(0, 1)) base = -base;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: base = 64'h8000_0000_0000_0000;
                        1: base = 64'h7fff_ffff_ffff_ffff;
                        2: base = -64'sd1;
                        default: base = {$urandom, $urandom} & 64'h0000_0000_ffff_ffff;
                    endcase
                end
            endcase
            // mostly short exponents keep the run short, full width now and then
            width    = ($urandom_range(0, 7) == 0) ? EXP_W : $urandom_range(0, 12);
            exponent = (width == EXP_W) ? $urandom : ($urandom & ((32'd1 << width) - 1));
            send_power(base, exponent);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_base     = '0;
        i_exponent = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_exponent_zero();
        test_extreme_operands();
        test_wraparound();
        test_exponent_patterns();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(RAND_ITEMS / 5);
        send_idle_pct  = 53;
        test_random_traffic(RAND_ITEMS / 5);
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        test_random_traffic(RAND_ITEMS / 5);
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        test_random_traffic(RAND_ITEMS / 5);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(RAND_ITEMS / 5);
        i_valid <= 1'b0;

        while (pending_powers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d powers with zero, extreme and wrapping operands", items_sent);
        $display("checked %0d results under sender gaps and receiver stalls", powers_checked);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
